// ===== src/cc20_pkg.sv =====
// Types, constants and helper functions for the ChaCha20 stream cipher.
package cc20_pkg;

  localparam int WORD_W   = 32;
  localparam int ITEM_W   = 64;
  localparam int COUNT_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_WORDS = 16;
  localparam int ITEM_BYTES = 8;
  localparam int BLOCK_ITEMS = 8;
  localparam int NUM_DROUNDS = 10;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_WORDS-1:0] block_t;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CTR = 3'd6;

  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  typedef struct packed {
    logic [ITEM_W-1:0]  data_in;
    logic [COUNT_W-1:0] byte_count;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [ITEM_W-1:0]  data_out;
    logic [COUNT_W-1:0] byte_count_out;
    logic               last_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  function automatic word_t rotl(input word_t v, input logic [1:0] step);
    word_t r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  function automatic block_t init_state(
    input logic [ITEM_W-1:0] k0,
    input logic [ITEM_W-1:0] k1,
    input logic [ITEM_W-1:0] k2,
    input logic [ITEM_W-1:0] k3,
    input logic [ITEM_W-1:0] n_lo,
    input word_t             n_hi,
    input word_t             ctr
  );
    block_t s;
    s[0]  = SIGMA_0;
    s[1]  = SIGMA_1;
    s[2]  = SIGMA_2;
    s[3]  = SIGMA_3;
    s[4]  = k0[31:0];
    s[5]  = k0[63:32];
    s[6]  = k1[31:0];
    s[7]  = k1[63:32];
    s[8]  = k2[31:0];
    s[9]  = k2[63:32];
    s[10] = k3[31:0];
    s[11] = k3[63:32];
    s[12] = ctr;
    s[13] = n_lo[31:0];
    s[14] = n_lo[63:32];
    s[15] = n_hi;
    return s;
  endfunction

endpackage

// ===== src/chacha20_stream_cipher.sv =====
// ChaCha20 stream cipher: 8-byte items XORed with the RFC 8439 keystream.
//
//  channel  | signals                           | direction
//  ---------+-----------------------------------+----------
//  input    | in_valid, in_stall, in_data       | item in
//  output   | out_valid, out_stall, out_data    | item out
//  config   | cfg_valid, cfg_ready, cfg_index,  | write in
//           | cfg_data                          |
//
// One item in flight. An item that opens a 64-byte block passes through the
// four-lane quarter-round step unit (one add/xor/rotate step per lane per
// cycle, 8 steps per double round), then the feed-forward add, then the emit
// state. Other items go from idle straight to emit. Synchronous reset clears
// control and config. A result waits in the output register under out_stall
// while the next item is taken and worked on.
module chacha20_stream_cipher
  import cc20_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ITEM_W-1:0]    cfg_data
);

  state_t state;

  logic [ITEM_W-1:0] key_0, key_1, key_2, key_3, nonce_lo;
  word_t             nonce_hi, start_ctr;

  word_t             block_counter;
  logic [2:0]        block_pos;
  logic              in_message;

  logic [1:0]        step;
  logic              diag;
  logic [3:0]        dround;

  block_t            work;
  block_t            work_next;
  logic [ITEM_W-1:0] ks [BLOCK_ITEMS];

  logic [ITEM_W-1:0]  data_reg;
  logic [COUNT_W-1:0] count_reg;
  logic               last_reg;

  logic               accept;
  logic               emit_ok;
  word_t              ctr_eff;
  logic [COUNT_W-1:0] count_eff;
  block_t             init_ctr;
  block_t             init_blk;
  logic [ITEM_W-1:0]  mask;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign emit_ok   = !out_valid || !out_stall;
  assign ctr_eff   = in_message ? block_counter : start_ctr;

  assign init_ctr = init_state(key_0, key_1, key_2, key_3, nonce_lo, nonce_hi, ctr_eff);
  assign init_blk = init_state(key_0, key_1, key_2, key_3, nonce_lo, nonce_hi,
                               block_counter);

  always_comb begin
    if (!in_data.last) begin
      count_eff = FULL_COUNT;
    end else if (in_data.byte_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (in_data.byte_count > FULL_COUNT) begin
      count_eff = FULL_COUNT;
    end else begin
      count_eff = in_data.byte_count;
    end
  end

  always_comb begin
    for (int b = 0; b < ITEM_BYTES; b++) begin
      mask[8*b +: 8] = (COUNT_W'(b) < count_reg) ? 8'hff : 8'h00;
    end
  end

  // shared step unit: four quarter-round lanes, one add/xor/rotate per lane
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    word_t      sum, mix;
    work_next = work;
    for (int i = 0; i < 4; i++) begin
      ia = 4'(i);
      ib = diag ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
      ic = diag ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
      id = diag ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
      if (!step[0]) begin
        sum = work[ia] + work[ib];
        mix = work[id] ^ sum;
        work_next[ia] = sum;
        work_next[id] = rotl(mix, step);
      end else begin
        sum = work[ic] + work[id];
        mix = work[ib] ^ sum;
        work_next[ic] = sum;
        work_next[ib] = rotl(mix, step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_0     <= '0;
      key_1     <= '0;
      key_2     <= '0;
      key_3     <= '0;
      nonce_lo  <= '0;
      nonce_hi  <= '0;
      start_ctr <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_0:     key_0     <= cfg_data;
        CFG_KEY_1:     key_1     <= cfg_data;
        CFG_KEY_2:     key_2     <= cfg_data;
        CFG_KEY_3:     key_3     <= cfg_data;
        CFG_NONCE_LO:  nonce_lo  <= cfg_data;
        CFG_NONCE_HI:  nonce_hi  <= cfg_data[WORD_W-1:0];
        CFG_START_CTR: start_ctr <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      block_counter <= '0;
      block_pos     <= '0;
      in_message    <= 1'b0;
      step          <= '0;
      diag          <= 1'b0;
      dround        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == ST_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!in_message) begin
              block_counter <= start_ctr;
              block_pos     <= '0;
            end
            if (!in_message || block_pos == '0) begin
              step   <= '0;
              diag   <= 1'b0;
              dround <= '0;
              state  <= ST_ROUND;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_ROUND: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            diag <= !diag;
            if (diag) begin
              if (dround == 4'(NUM_DROUNDS - 1)) begin
                state <= ST_FINAL;
              end else begin
                dround <= dround + 4'd1;
              end
            end
          end
        end
        ST_FINAL: begin
          block_counter <= block_counter + 32'd1;
          state         <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            in_message <= !last_reg;
            block_pos  <= last_reg ? 3'd0 : block_pos + 3'd1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      data_reg  <= in_data.data_in;
      count_reg <= count_eff;
      last_reg  <= in_data.last;
      work      <= init_ctr;
    end else if (state == ST_ROUND) begin
      work <= work_next;
    end
    if (state == ST_FINAL) begin
      for (int j = 0; j < BLOCK_ITEMS; j++) begin
        ks[j] <= {work[2*j+1] + init_blk[2*j+1], work[2*j] + init_blk[2*j]};
      end
    end else if (state == ST_EMIT && emit_ok) begin
      // move the next 8 keystream bytes to the head
      for (int j = 0; j < BLOCK_ITEMS - 1; j++) begin
        ks[j] <= ks[j+1];
      end
      out_data.data_out       <= (data_reg ^ ks[0]) & mask;
      out_data.byte_count_out <= count_reg;
      out_data.last_out       <= last_reg;
    end
  end

endmodule

// ===== tb/cc20_stream_checker.sv =====
// Checker for the ChaCha20 stream cipher: predicts each result item and compares it.
`timescale 1ns / 1ps

module cc20_stream_checker
  import cc20_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ITEM_W-1:0]    cfg_data,
  input  logic                 check_end,
  output int                   pending,
  output int                   fail_count
);

  // register copies
  logic [ITEM_W-1:0] key_reg [4];
  logic [ITEM_W-1:0] nonce_lo_reg;
  word_t             nonce_hi_reg;
  word_t             start_ctr_reg;

  // cipher state
  word_t       ks_words [16];
  word_t       mix [16];
  logic [2:0]  blk_pos;
  word_t       blk_ctr;
  logic        msg_open;

  out_item_t   cipher_expected [$];
  int          n_results;
  logic        end_seen;

  task report(string msg);
    fail_count++;
    if (fail_count <= 100) $display("ERROR: %s", msg);
  endtask

  function automatic word_t rol(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void qround(int a, int b, int c, int d);
    mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], 16);
    mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], 12);
    mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], 8);
    mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], 7);
  endfunction

  // key and nonce are taken fresh for every block
  function void make_keystream();
    word_t seed [16];
    seed[0] = SIGMA_0;
    seed[1] = SIGMA_1;
    seed[2] = SIGMA_2;
    seed[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      seed[4 + 2*i] = key_reg[i][31:0];
      seed[5 + 2*i] = key_reg[i][63:32];
    end
    seed[12] = blk_ctr;
    seed[13] = nonce_lo_reg[31:0];
    seed[14] = nonce_lo_reg[63:32];
    seed[15] = nonce_hi_reg;
    mix = seed;
    for (int r = 0; r < NUM_DROUNDS; r++) begin
      qround(0, 4, 8, 12);
      qround(1, 5, 9, 13);
      qround(2, 6, 10, 14);
      qround(3, 7, 11, 15);
      qround(0, 5, 10, 15);
      qround(1, 6, 11, 12);
      qround(2, 7, 8, 13);
      qround(3, 4, 9, 14);
    end
    for (int i = 0; i < NUM_WORDS; i++) ks_words[i] = mix[i] + seed[i];
    blk_ctr = blk_ctr + 1;
  endfunction

  function out_item_t predict_cipher_item(in_item_t it);
    out_item_t          res;
    logic [2:0]         p;
    logic [COUNT_W-1:0] n;
    logic [ITEM_W-1:0]  stream;
    logic [ITEM_W-1:0]  mask;
    if (!msg_open) begin
      blk_ctr = start_ctr_reg;
      blk_pos = '0;
    end
    p = blk_pos;
    if (p == 0) make_keystream();
    stream = {ks_words[2*p + 1], ks_words[2*p]};
    // count only matters on the last item; 0 means one byte, above 8 saturates
    if (!it.last) n = FULL_COUNT;
    else if (it.byte_count == 0) n = COUNT_W'(1);
    else if (it.byte_count > FULL_COUNT) n = FULL_COUNT;
    else n = it.byte_count;
    mask = (n >= FULL_COUNT) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    res.data_out       = (it.data_in ^ stream) & mask;
    res.byte_count_out = n;
    res.last_out       = it.last;
    if (it.last) begin
      msg_open = 1'b0;
      blk_pos  = '0;
    end else begin
      msg_open = 1'b1;
      blk_pos  = p + 3'd1;
    end
    return res;
  endfunction

  function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [ITEM_W-1:0] d);
    case (idx)
      CFG_KEY_0:     key_reg[0] = d;
      CFG_KEY_1:     key_reg[1] = d;
      CFG_KEY_2:     key_reg[2] = d;
      CFG_KEY_3:     key_reg[3] = d;
      CFG_NONCE_LO:  nonce_lo_reg = d;
      CFG_NONCE_HI:  nonce_hi_reg = d[31:0];
      CFG_START_CTR: start_ctr_reg = d[31:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      nonce_lo_reg  = '0;
      nonce_hi_reg  = '0;
      start_ctr_reg = '0;
      for (int i = 0; i < NUM_WORDS; i++) ks_words[i] = '0;
      blk_pos   = '0;
      blk_ctr   = '0;
      msg_open  = 1'b0;
      n_results = 0;
      end_seen  = 1'b0;
      cipher_expected.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_valid && !in_stall) cipher_expected.push_back(predict_cipher_item(in_data));
      if (out_valid && !out_stall) begin
        if (cipher_expected.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          want = cipher_expected.pop_front();
          if (out_data.data_out !== want.data_out)
            report($sformatf("result %0d data_out %h, expected %h",
                             n_results, out_data.data_out, want.data_out));
          if (out_data.byte_count_out !== want.byte_count_out)
            report($sformatf("result %0d byte_count_out %0d, expected %0d",
                             n_results, out_data.byte_count_out, want.byte_count_out));
          if (out_data.last_out !== want.last_out)
            report($sformatf("result %0d last_out %b, expected %b",
                             n_results, out_data.last_out, want.last_out));
        end
        n_results++;
      end
      if (check_end && !end_seen) begin
        end_seen = 1'b1;
        if (cipher_expected.size() != 0)
          report($sformatf("%0d expected results never arrived", cipher_expected.size()));
      end
      pending <= cipher_expected.size();
    end
  end

endmodule

// ===== tb/tb_chacha20_stream_cipher.sv =====
// Testbench top for the ChaCha20 stream cipher: stimulus, config writes and verdict.
`timescale 1ns / 1ps

module tb_chacha20_stream_cipher
  import cc20_pkg::*;
();

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ITEM_W-1:0]    cfg_data = '0;
  logic                 check_end = 1'b0;
  int                   pending;
  int                   fail_count;

  // idling switches, changed per phase
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chacha20_stream_cipher i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cc20_stream_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .check_end  (check_end),
    .pending    (pending),
    .fail_count (fail_count)
  );

  function automatic in_item_t mk_item(logic [ITEM_W-1:0] d, logic [COUNT_W-1:0] n, logic l);
    in_item_t it;
    it.data_in    = d;
    it.byte_count = n;
    it.last       = l;
    return it;
  endfunction

  function automatic logic [ITEM_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // returns at the edge where the item is taken; valid stays up if the next one follows
  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message(int len);
    logic               is_last;
    logic [COUNT_W-1:0] n;
    for (int i = 0; i < len; i++) begin
      is_last = (i == len - 1);
      if (!is_last) n = COUNT_W'($urandom_range(0, 15));
      else if ($urandom_range(0, 7) == 0) n = COUNT_W'($urandom_range(0, 15));
      else n = COUNT_W'($urandom_range(1, 8));
      send_item(mk_item(rand_word(), n, is_last));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ITEM_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_all(logic [ITEM_W-1:0] k0, logic [ITEM_W-1:0] k1,
                           logic [ITEM_W-1:0] k2, logic [ITEM_W-1:0] k3,
                           logic [ITEM_W-1:0] n_lo, logic [ITEM_W-1:0] n_hi,
                           logic [ITEM_W-1:0] ctr);
    write_reg(CFG_KEY_0, k0);
    write_reg(CFG_KEY_1, k1);
    write_reg(CFG_KEY_2, k2);
    write_reg(CFG_KEY_3, k3);
    write_reg(CFG_NONCE_LO, n_lo);
    write_reg(CFG_NONCE_HI, n_hi);
    write_reg(CFG_START_CTR, ctr);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stall per item while rx_idle, two long hold-offs to back up the block
  initial begin
    int stall_len;
    int rx_seen;
    rx_seen = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (rx_seen == 120 || rx_seen == 900) stall_len = 300;
      else stall_len = rx_idle ? $urandom_range(0, 18) : 0;
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_seen++;
    end
  end

  initial begin
    int          phase_items;
    int          len;
    logic [63:0] ctr;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset: all-zero key, nonce and counter
    send_item(mk_item('1, FULL_COUNT, 1'b1));
    send_item(mk_item(64'h0123_4567_89ab_cdef, 4'd0, 1'b1));
    send_item(mk_item('1, 4'd1, 1'b1));
    wait_drained();

    // known key 00..1f, nonce ..4a.., counter 1
    write_all(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
              64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
              64'h4a00_0000_0000_0000, 64'h0, 64'h1);
    send_item(mk_item('0, 4'd0, 1'b0));
    send_item(mk_item('1, 4'd5, 1'b0));
    send_item(mk_item(rand_word(), 4'd15, 1'b0));
    send_item(mk_item(rand_word(), FULL_COUNT, 1'b0));
    send_item(mk_item(rand_word(), 4'd3, 1'b0));
    send_item(mk_item(rand_word(), 4'd9, 1'b0));
    // key change mid-message shows up only at the next block;
    // a new start counter is ignored until the next message
    wait_drained();
    write_reg(CFG_KEY_2, {$urandom, $urandom});
    write_reg(CFG_START_CTR, 64'h0000_0000_dead_beef);
    cfg_valid <= 1'b0;
    send_item(mk_item(rand_word(), 4'd2, 1'b0));
    send_item(mk_item(rand_word(), 4'd7, 1'b0));
    send_item(mk_item(rand_word(), 4'd15, 1'b1));
    wait_drained();

    // all-ones settings; counter wraps after the first block
    write_all('1, '1, '1, '1, '1, '1, 64'h0000_0000_ffff_ffff);
    for (int i = 0; i < 8; i++) send_item(mk_item(rand_word(), 4'd0, 1'b0));
    send_item(mk_item(rand_word(), 4'd9, 1'b1));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      tx_idle <= (p % 4 == 0) || (p % 4 == 1);
      rx_idle <= (p % 4 == 0) || (p % 4 == 3);
      case ($urandom_range(0, 3))
        0:       ctr = 64'h0;
        1:       ctr = {$urandom, 32'hffff_ffff};
        2:       ctr = {$urandom, 32'hffff_fff0 + 32'($urandom_range(0, 15))};
        default: ctr = {$urandom, $urandom};
      endcase
      write_all(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                {$urandom, $urandom}, ctr);
      phase_items = 0;
      while (phase_items < 175) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_message(len);
        phase_items += len;
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    check_end <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/cc20_pkg.sv
src/chacha20_stream_cipher.sv
tb/cc20_stream_checker.sv
tb/tb_chacha20_stream_cipher.sv
